// ===== src/flc_pkg.sv =====
// Shared types, constants and tables of the free-look camera pose block.
// No dependencies; every other file in src imports this package.
package flc_pkg;

    localparam int POS_W     = 32;
    localparam int DIR_W     = 16;
    localparam int STEP_W    = 23;
    localparam int POLAR_W   = 15;
    localparam int ANG_W     = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Internal widths of the arithmetic units.
    localparam int CORDIC_XW    = 34;
    localparam int CORDIC_ZW    = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_CW    = 4;
    localparam int SQ_W         = 62;
    localparam int ROOT_W       = 32;
    localparam int DIVD_W       = 46;
    localparam int QUO_W        = 15;
    localparam int ACC_W        = 64;

    localparam logic signed [DIR_W-1:0] ONE_Q14 = 16'sd16384;

    localparam logic [POLAR_W-1:0] POLAR_MIN  = 15'd2458;
    localparam logic [POLAR_W-1:0] POLAR_MAX  = 15'd23279;
    localparam logic [POLAR_W-1:0] POLAR_HOME = 15'd12868;
    localparam logic [ANG_W-1:0]   AZ_HOME    = 16'd38604;
    localparam logic [ANG_W-1:0]   AZ_WRAP    = 16'd51472;

    // Angle fold points in Q.16.
    localparam logic [18:0] HALF_PI16       = 19'd102944;
    localparam logic [18:0] PI16            = 19'd205887;
    localparam logic [18:0] THREE_HALF_PI16 = 19'd308831;
    localparam logic [18:0] TWO_PI16        = 19'd411775;

    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [KIND_W-1:0] {
        KIND_FWD,
        KIND_BACK,
        KIND_RIGHT,
        KIND_LEFT,
        KIND_UP,
        KIND_DOWN,
        KIND_LOOK,
        KIND_HOME
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOME_X,
        CFG_HOME_Y,
        CFG_HOME_Z,
        CFG_UP_X,
        CFG_UP_Y,
        CFG_UP_Z,
        CFG_STEP
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE,
        ST_CP_GO,
        ST_CP_WAIT,
        ST_CA_GO,
        ST_CA_WAIT,
        ST_FWD,
        ST_CROSS,
        ST_SQ,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } seq_state_t;

    // Arctangent of 2^-i in Q.16.
    function automatic logic signed [CORDIC_ZW-1:0] atan_q16(input logic [CORDIC_CW-1:0] i);
        logic signed [CORDIC_ZW-1:0] r;
        case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

endpackage

// ===== src/flc_cordic.sv =====
// Iterative rotation-mode CORDIC: sine and cosine of a Q3.13 angle in Q2.14.
// Depends on flc_pkg; one micro-rotation per cycle.
module flc_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [flc_pkg::ANG_W-1:0]         angle,
    output logic                              done,
    output logic signed [flc_pkg::DIR_W-1:0]  sin_out,
    output logic signed [flc_pkg::DIR_W-1:0]  cos_out
);
    import flc_pkg::*;

    localparam logic signed [CORDIC_XW-1:0] RND  = 34'sd32768;
    localparam logic signed [CORDIC_XW-1:0] LIM  = 34'sd16384;
    localparam logic signed [CORDIC_XW-1:0] NLIM = -34'sd16384;

    logic signed [CORDIC_XW-1:0] x_reg, y_reg, x_next, y_next, x_sh, y_sh;
    logic signed [CORDIC_ZW-1:0] z_reg, z_next, z_init, atan_v;
    logic                        neg_reg, neg_init;
    logic [CORDIC_CW-1:0]        cnt_reg;
    logic                        busy_reg, done_reg;
    logic [18:0]                 a_scaled;
    logic signed [DIR_W-1:0]     s_q14, c_q14;

    function automatic logic signed [DIR_W-1:0] to_q14(input logic signed [CORDIC_XW-1:0] v);
        logic signed [CORDIC_XW-1:0] r;
        r = (v + RND) >>> 16;
        if (r > LIM)
            return ONE_Q14;
        else if (r < NLIM)
            return -ONE_Q14;
        else
            return r[DIR_W-1:0];
    endfunction

    // Fold the angle into the right half plane.
    always_comb
    begin
        a_scaled = {angle, 3'b000};
        if (a_scaled <= HALF_PI16)
        begin
            z_init   = signed'({1'b0, a_scaled});
            neg_init = 1'b0;
        end
        else if (a_scaled <= THREE_HALF_PI16)
        begin
            z_init   = signed'({1'b0, a_scaled}) - signed'({1'b0, PI16});
            neg_init = 1'b1;
        end
        else
        begin
            z_init   = signed'({1'b0, a_scaled}) - signed'({1'b0, TWO_PI16});
            neg_init = 1'b0;
        end
    end

    // One micro-rotation.
    always_comb
    begin
        x_sh   = x_reg >>> cnt_reg;
        y_sh   = y_reg >>> cnt_reg;
        atan_v = atan_q16(cnt_reg);
        if (!z_reg[CORDIC_ZW-1])
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_v;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_v;
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CORDIC_CW'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Rotation registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_init;
            neg_reg <= neg_init;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // Round, clamp and undo the fold.
    assign c_q14   = to_q14(x_reg);
    assign s_q14   = to_q14(y_reg);
    assign cos_out = neg_reg ? -c_q14 : c_q14;
    assign sin_out = neg_reg ? -s_q14 : s_q14;
    assign done    = done_reg;

endmodule

// ===== src/flc_root.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on flc_pkg.
module flc_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [flc_pkg::SQ_W-1:0]    value,
    output logic                        done,
    output logic [flc_pkg::ROOT_W-1:0]  root
);
    import flc_pkg::*;

    localparam logic [ACC_W-1:0] ROOT_TOP = 64'h4000_0000_0000_0000;

    logic [ACC_W-1:0] v_reg, res_reg, bit_reg, sum;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg, ge;

    // Trial subtraction.
    assign sum = res_reg + bit_reg;
    assign ge  = (v_reg >= sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= {2'b00, value};
            res_reg <= '0;
            bit_reg <= ROOT_TOP;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[ROOT_W-1:0];
    assign done = done_reg;

endmodule

// ===== src/flc_div.sv =====
// Restoring divider for the right-vector scaling, one quotient bit per cycle.
// Depends on flc_pkg; the quotient is known to fit in QUO_W bits.
module flc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [flc_pkg::DIVD_W-1:0]  dividend,
    input  logic [flc_pkg::ROOT_W-1:0]  divisor,
    output logic                        done,
    output logic [flc_pkg::QUO_W-1:0]   quotient
);
    import flc_pkg::*;

    logic [ROOT_W:0]   rem_reg, trial;
    logic [QUO_W-1:0]  low_reg, q_reg;
    logic [3:0]        cnt_reg;
    logic              busy_reg, done_reg, ge;

    // Shift in the next dividend bit and compare.
    assign trial = {rem_reg[ROOT_W-1:0], low_reg[QUO_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 4'(QUO_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, dividend[DIVD_W-1:QUO_W]};
            low_reg <= dividend[QUO_W-1:0];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, divisor}) : trial;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== src/free_look_camera_pose_top.sv =====
// Free-look camera pose: keeps position, forward and right vectors and the
// polar and azimuth angles, and returns the new pose word for every command.
// Depends on flc_pkg, flc_cordic, flc_root and flc_div.
//
// One command is in flight at a time: cmd_ready is high only while idle, and
// the pose word is held on the outputs until taken. A move makes one pass of
// the shared multiplier per axis, a re-home goes straight to the output, and a
// look does two 16-step CORDIC runs, 11 multiplier passes for forward, the
// cross product and its square, a 32-step square root and three 15-step
// divisions. A look whose cross product is zero skips the divisions.
// Configuration writes take effect at once and are meant for idle.
module free_look_camera_pose_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_en,
    input  logic [flc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [flc_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  logic [flc_pkg::KIND_W-1:0]            kind,
    input  logic signed [flc_pkg::ANG_W-1:0]      d_theta,
    input  logic signed [flc_pkg::ANG_W-1:0]      d_phi,
    output logic                                  pose_valid,
    input  logic                                  pose_ready,
    output logic signed [flc_pkg::POS_W-1:0]      pos_x,
    output logic signed [flc_pkg::POS_W-1:0]      pos_y,
    output logic signed [flc_pkg::POS_W-1:0]      pos_z,
    output logic signed [flc_pkg::DIR_W-1:0]      fwd_x,
    output logic signed [flc_pkg::DIR_W-1:0]      fwd_y,
    output logic signed [flc_pkg::DIR_W-1:0]      fwd_z,
    output logic signed [flc_pkg::DIR_W-1:0]      right_x,
    output logic signed [flc_pkg::DIR_W-1:0]      right_y,
    output logic signed [flc_pkg::DIR_W-1:0]      right_z,
    output logic [flc_pkg::POLAR_W-1:0]           polar,
    output logic [flc_pkg::ANG_W-1:0]             azimuth
);
    import flc_pkg::*;

    localparam logic signed [33:0] POS_MAX34 = 34'sd2147483647;
    localparam logic signed [33:0] POS_MIN34 = -34'sd2147483648;
    localparam logic signed [ACC_W-1:0] RND14 = 64'sd8192;

    // Configuration and pose state.
    logic signed [POS_W-1:0] home_reg [3];
    logic signed [DIR_W-1:0] up_reg [3];
    logic [STEP_W-1:0]       step_reg;
    logic signed [POS_W-1:0] pos_reg [3];
    logic signed [DIR_W-1:0] fwd_reg [3];
    logic signed [DIR_W-1:0] right_reg [3];
    logic [POLAR_W-1:0]      polar_reg;
    logic [ANG_W-1:0]        azimuth_reg;

    // Sequencer and scratch.
    seq_state_t              state_reg, state_next;
    logic [2:0]              cnt_reg, cnt_next;
    kind_t                   kind_reg;
    logic signed [DIR_W-1:0] sp_reg, cp_reg;
    logic signed [31:0]      cr_reg [3];
    logic signed [31:0]      tmp_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [ROOT_W-1:0]       n_reg;
    logic signed [ACC_W-1:0] mul_reg;

    logic signed [31:0]      mul_a, mul_b;
    logic [1:0]              idx, cidx;
    logic [2:0]              kcross;
    logic signed [ACC_W-1:0] rnd14;
    logic signed [33:0]      d34, sum34;
    logic signed [POS_W-1:0] pos_sat;
    logic signed [17:0]      psum, asum;
    logic [POLAR_W-1:0]      polar_new;
    logic [ANG_W-1:0]        az_new;
    logic                    accept, move_neg;

    logic                    cordic_start, cordic_done;
    logic [ANG_W-1:0]        cordic_angle;
    logic signed [DIR_W-1:0] cordic_sin, cordic_cos;
    logic                    root_start, root_done;
    logic [ROOT_W-1:0]       root_val;
    logic                    div_start, div_done;
    logic [DIVD_W-1:0]       div_dividend;
    logic [QUO_W-1:0]        div_q;
    logic [30:0]             cr_mag;

    assign accept = cmd_valid && cmd_ready;
    assign idx    = cnt_reg[1:0];
    assign cidx   = cnt_reg[1:0] - 2'd1;
    assign kcross = cnt_reg - 3'd1;

    // Shared units.
    assign cordic_angle = (state_reg == ST_CA_GO) ? azimuth_reg : {1'b0, polar_reg};

    flc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_out (cordic_sin),
        .cos_out (cordic_cos)
    );

    flc_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sq_reg),
        .done  (root_done),
        .root  (root_val)
    );

    assign cr_mag       = cr_reg[idx][31] ? 31'(-cr_reg[idx]) : cr_reg[idx][30:0];
    assign div_dividend = (DIVD_W'(cr_mag) << 14) + DIVD_W'(n_reg >> 1);

    flc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // New angles for a look command.
    always_comb
    begin
        psum = signed'({3'b000, polar_reg}) + 18'(d_theta);
        if (psum < signed'({3'b000, POLAR_MIN}))
            polar_new = POLAR_MIN;
        else if (psum > signed'({3'b000, POLAR_MAX}))
            polar_new = POLAR_MAX;
        else
            polar_new = psum[POLAR_W-1:0];
        asum = signed'({2'b00, azimuth_reg}) + 18'(d_phi);
        if (asum < 18'sd0)
            az_new = 16'(asum + signed'({2'b00, AZ_WRAP}));
        else if (asum >= signed'({2'b00, AZ_WRAP}))
            az_new = 16'(asum - signed'({2'b00, AZ_WRAP}));
        else
            az_new = asum[ANG_W-1:0];
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MOVE:
            begin
                mul_a = signed'({9'd0, step_reg});
                if (cnt_reg < 3'd3)
                begin
                    if (kind_reg == KIND_FWD || kind_reg == KIND_BACK)
                        mul_b = 32'(fwd_reg[idx]);
                    else if (kind_reg == KIND_RIGHT || kind_reg == KIND_LEFT)
                        mul_b = 32'(right_reg[idx]);
                    else if (idx == 2'd1)
                        mul_b = 32'(ONE_Q14);
                end
            end
            ST_FWD:
            begin
                mul_a = 32'(sp_reg);
                mul_b = (cnt_reg == 3'd0) ? 32'(cordic_cos) : 32'(cordic_sin);
            end
            ST_CROSS:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        mul_a = 32'(fwd_reg[1]);
                        mul_b = 32'(up_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = 32'(fwd_reg[2]);
                        mul_b = 32'(up_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = 32'(fwd_reg[2]);
                        mul_b = 32'(up_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = 32'(fwd_reg[0]);
                        mul_b = 32'(up_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = 32'(fwd_reg[0]);
                        mul_b = 32'(up_reg[1]);
                    end
                    3'd5:
                    begin
                        mul_a = 32'(fwd_reg[1]);
                        mul_b = 32'(up_reg[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_SQ:
            begin
                if (cnt_reg < 3'd3)
                begin
                    mul_a = cr_reg[idx];
                    mul_b = cr_reg[idx];
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounded product and saturating position update.
    always_comb
    begin
        rnd14    = (mul_reg + RND14) >>> 14;
        d34      = rnd14[33:0];
        move_neg = (kind_reg == KIND_BACK) || (kind_reg == KIND_LEFT) ||
                   (kind_reg == KIND_DOWN);
        sum34    = 34'(pos_reg[cidx]) + (move_neg ? -d34 : d34);
        if (sum34 > POS_MAX34)
            pos_sat = POS_MAX34[POS_W-1:0];
        else if (sum34 < POS_MIN34)
            pos_sat = POS_MIN34[POS_W-1:0];
        else
            pos_sat = sum34[POS_W-1:0];
    end

    // Sequencer: next state and unit starts.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cordic_start = 1'b0;
        root_start   = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cmd_valid)
                begin
                    case (kind)
                        KIND_LOOK: state_next = ST_CP_GO;
                        KIND_HOME: state_next = ST_DONE;
                        default:   state_next = ST_MOVE;
                    endcase
                end
            end
            ST_MOVE:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                    state_next = ST_DONE;
            end
            ST_CP_GO:
            begin
                cordic_start = 1'b1;
                state_next   = ST_CP_WAIT;
            end
            ST_CP_WAIT:
            begin
                if (cordic_done)
                    state_next = ST_CA_GO;
            end
            ST_CA_GO:
            begin
                cordic_start = 1'b1;
                state_next   = ST_CA_WAIT;
            end
            ST_CA_WAIT:
            begin
                cnt_next = '0;
                if (cordic_done)
                    state_next = ST_FWD;
            end
            ST_FWD:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd2)
                begin
                    cnt_next   = '0;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                    state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                cnt_next = '0;
                if (root_done)
                    state_next = (root_val == '0) ? ST_DONE : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = (cnt_reg == 3'd2) ? ST_DONE : ST_DIV_GO;
                end
            end
            ST_DONE:
            begin
                if (pose_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_reg[0] <= '0;
            home_reg[1] <= '0;
            home_reg[2] <= '0;
            up_reg[0]   <= '0;
            up_reg[1]   <= ONE_Q14;
            up_reg[2]   <= '0;
            step_reg    <= 23'd268698;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_HOME_X: home_reg[0] <= cfg_data[POS_W-1:0];
                CFG_HOME_Y: home_reg[1] <= cfg_data[POS_W-1:0];
                CFG_HOME_Z: home_reg[2] <= cfg_data[POS_W-1:0];
                CFG_UP_X:   up_reg[0]   <= cfg_data[DIR_W-1:0];
                CFG_UP_Y:   up_reg[1]   <= cfg_data[DIR_W-1:0];
                CFG_UP_Z:   up_reg[2]   <= cfg_data[DIR_W-1:0];
                CFG_STEP:   step_reg    <= cfg_data[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Pose state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            pos_reg[2]   <= '0;
            fwd_reg[0]   <= '0;
            fwd_reg[1]   <= '0;
            fwd_reg[2]   <= -ONE_Q14;
            right_reg[0] <= ONE_Q14;
            right_reg[1] <= '0;
            right_reg[2] <= '0;
            polar_reg    <= POLAR_HOME;
            azimuth_reg  <= AZ_HOME;
        end
        else
        begin
            if (accept && kind == KIND_LOOK)
            begin
                polar_reg   <= polar_new;
                azimuth_reg <= az_new;
            end
            else if (accept && kind == KIND_HOME)
            begin
                pos_reg[0]   <= home_reg[0];
                pos_reg[1]   <= home_reg[1];
                pos_reg[2]   <= home_reg[2];
                fwd_reg[0]   <= '0;
                fwd_reg[1]   <= '0;
                fwd_reg[2]   <= -ONE_Q14;
                right_reg[0] <= ONE_Q14;
                right_reg[1] <= '0;
                right_reg[2] <= '0;
                polar_reg    <= POLAR_HOME;
                azimuth_reg  <= AZ_HOME;
            end
            if (state_reg == ST_MOVE && cnt_reg != 3'd0)
                pos_reg[cidx] <= pos_sat;
            if (state_reg == ST_FWD)
            begin
                case (cnt_reg)
                    3'd0:    fwd_reg[1] <= cp_reg;
                    3'd1:    fwd_reg[0] <= rnd14[DIR_W-1:0];
                    3'd2:    fwd_reg[2] <= rnd14[DIR_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DIV_WAIT && div_done)
                right_reg[idx] <= cr_reg[idx][31] ? -DIR_W'(div_q) : DIR_W'(div_q);
        end
    end

    // Scratch registers: the product, the command kind and the look intermediates.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        if (accept)
            kind_reg <= kind_t'(kind);
        if (state_reg == ST_CP_WAIT && cordic_done)
        begin
            sp_reg <= cordic_sin;
            cp_reg <= cordic_cos;
        end
        if (state_reg == ST_CROSS && cnt_reg != 3'd0)
        begin
            if (!kcross[0])
                tmp_reg <= mul_reg[31:0];
            else
                cr_reg[kcross[2:1]] <= tmp_reg - mul_reg[31:0];
        end
        if (state_reg == ST_SQ && cnt_reg != 3'd0)
        begin
            if (cnt_reg == 3'd1)
                sq_reg <= mul_reg[SQ_W-1:0];
            else
                sq_reg <= sq_reg + mul_reg[SQ_W-1:0];
        end
        if (state_reg == ST_ROOT_WAIT && root_done)
            n_reg <= root_val;
    end

    // Ports.
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign pose_valid = (state_reg == ST_DONE);
    assign pos_x      = pos_reg[0];
    assign pos_y      = pos_reg[1];
    assign pos_z      = pos_reg[2];
    assign fwd_x      = fwd_reg[0];
    assign fwd_y      = fwd_reg[1];
    assign fwd_z      = fwd_reg[2];
    assign right_x    = right_reg[0];
    assign right_y    = right_reg[1];
    assign right_z    = right_reg[2];
    assign polar      = polar_reg;
    assign azimuth    = azimuth_reg;

    // A pose word and a new command never overlap.
    assert property (@(posedge clk) disable iff (!rst_n) pose_valid |-> !cmd_ready)
        else $error("pose word shown while a command can be taken");

    // An accepted command always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !cmd_ready)
        else $error("sequencer stayed idle after accepting a command");

    // The polar angle stays inside its clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid |-> (polar >= POLAR_MIN) && (polar <= POLAR_MAX))
        else $error("polar angle out of range");

    // The azimuth stays wrapped.
    assert property (@(posedge clk) disable iff (!rst_n) pose_valid |-> (azimuth < AZ_WRAP))
        else $error("azimuth not wrapped");

    // The x and z forward components stay unit bounded.
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid |-> (fwd_x <= ONE_Q14) && (fwd_x >= -ONE_Q14) &&
                       (fwd_z <= ONE_Q14) && (fwd_z >= -ONE_Q14))
        else $error("forward vector component exceeds one");

endmodule

// ===== tb/free_look_camera_pose_top_tb.sv =====
// Self-checking testbench for the free-look camera pose block.
// Depends on flc_pkg and free_look_camera_pose_top; predicts each pose word in place.
module free_look_camera_pose_top_tb;
    import flc_pkg::*;

    localparam int    IDLE_LIMIT  = 3000;
    localparam int    HOLD_CYCLES = 400;
    localparam int    SETTLE      = 160;
    localparam longint HALF_PI_Q16   = 102944;
    localparam longint PI_Q16        = 205887;
    localparam longint THREE_HALF_Q16 = 308831;
    localparam longint TWO_PI_Q16    = 411775;
    localparam longint GAIN          = 652032874;
    localparam longint POL_LO        = 2458;
    localparam longint POL_HI        = 23279;
    localparam longint AZ_RANGE      = 51472;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Signed like the block's ports, so both sides widen the same way.
    typedef struct {
        logic signed [POS_W-1:0] px, py, pz;
        logic signed [DIR_W-1:0] fx, fy, fz, rx, ry, rz;
        logic [POLAR_W-1:0]      pol;
        logic [ANG_W-1:0]        az;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    logic [KIND_W-1:0] kind = '0;
    logic signed [ANG_W-1:0] d_theta = '0;
    logic signed [ANG_W-1:0] d_phi = '0;
    logic pose_valid;
    logic pose_ready = 1'b0;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [DIR_W-1:0] fwd_x, fwd_y, fwd_z, right_x, right_y, right_z;
    logic [POLAR_W-1:0] polar;
    logic [ANG_W-1:0] azimuth;

    free_look_camera_pose_top dut (.*);

    always #5 clk = ~clk;

    // Camera state as the block should hold it.
    longint cam_pos[3], cam_fwd[3], cam_right[3], cam_pol, cam_az;
    longint home_val[3], up_val[3], step_val;
    longint atan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};

    pose_t pending_poses[$];
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int looks_sent = 0;
    int calm = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rotation-mode CORDIC over a folded Q.16 angle; results in Q2.14.
    function automatic void sin_cos_q14(input longint ang, output longint s,
                                        output longint c);
        longint a, z, x, y, nx;
        bit neg;
        a = ang * 8;
        neg = 1'b0;
        if (a <= HALF_PI_Q16)
            z = a;
        else if (a <= THREE_HALF_Q16)
        begin
            z = a - PI_Q16;
            neg = 1'b1;
        end
        else
            z = a - TWO_PI_Q16;
        x = GAIN;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_steps[i];
            end
            x = nx;
        end
        x = clampl((x + 32768) >>> 16, -16384, 16384);
        y = clampl((y + 32768) >>> 16, -16384, 16384);
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void shift_position(longint dir[3], int sgn);
        longint d;
        for (int i = 0; i < 3; i++)
        begin
            d = (step_val * dir[i] + 8192) >>> 14;
            cam_pos[i] = clampl(cam_pos[i] + (sgn > 0 ? d : -d),
                                -64'sd2147483648, 64'sd2147483647);
        end
    endfunction

    function automatic void turn_camera(longint dth, longint dph);
        longint sp, cp, sa, ca;
        longint cr[3];
        longint unsigned sq, n, m;
        cam_pol = clampl(cam_pol + dth, POL_LO, POL_HI);
        cam_az += dph;
        if (cam_az < 0)
            cam_az += AZ_RANGE;
        else if (cam_az >= AZ_RANGE)
            cam_az -= AZ_RANGE;
        sin_cos_q14(cam_pol, sp, cp);
        sin_cos_q14(cam_az, sa, ca);
        cam_fwd[0] = (sp * ca + 8192) >>> 14;
        cam_fwd[1] = cp;
        cam_fwd[2] = (sp * sa + 8192) >>> 14;
        cr[0] = cam_fwd[1] * up_val[2] - cam_fwd[2] * up_val[1];
        cr[1] = cam_fwd[2] * up_val[0] - cam_fwd[0] * up_val[2];
        cr[2] = cam_fwd[0] * up_val[1] - cam_fwd[1] * up_val[0];
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = cr[i] < 0 ? -cr[i] : cr[i];
            sq += m * m;
        end
        n = int_sqrt(sq);
        // A zero cross product leaves the right vector as it was.
        if (n == 0)
            return;
        for (int i = 0; i < 3; i++)
        begin
            m = cr[i] < 0 ? -cr[i] : cr[i];
            m = (m * 16384 + n / 2) / n;
            cam_right[i] = cr[i] < 0 ? -longint'(m) : longint'(m);
        end
    endfunction

    function automatic void go_home();
        for (int i = 0; i < 3; i++)
            cam_pos[i] = home_val[i];
        cam_fwd = '{0, 0, -16384};
        cam_right = '{16384, 0, 0};
        cam_pol = 12868;
        cam_az = 38604;
    endfunction

    function automatic pose_t next_pose(kind_t k, longint dth, longint dph);
        pose_t p;
        longint vertical[3] = '{0, 16384, 0};
        case (k)
            KIND_FWD:   shift_position(cam_fwd, 1);
            KIND_BACK:  shift_position(cam_fwd, -1);
            KIND_RIGHT: shift_position(cam_right, 1);
            KIND_LEFT:  shift_position(cam_right, -1);
            KIND_UP:    shift_position(vertical, 1);
            KIND_DOWN:  shift_position(vertical, -1);
            KIND_LOOK:  turn_camera(dth, dph);
            default:    go_home();
        endcase
        p.px = POS_W'(cam_pos[0]);
        p.py = POS_W'(cam_pos[1]);
        p.pz = POS_W'(cam_pos[2]);
        p.fx = DIR_W'(cam_fwd[0]);
        p.fy = DIR_W'(cam_fwd[1]);
        p.fz = DIR_W'(cam_fwd[2]);
        p.rx = DIR_W'(cam_right[0]);
        p.ry = DIR_W'(cam_right[1]);
        p.rz = DIR_W'(cam_right[2]);
        p.pol = POLAR_W'(cam_pol);
        p.az = ANG_W'(cam_az);
        return p;
    endfunction

    // Send one command word; valid stays high until the block takes it.
    task automatic send_cmd(kind_t k, logic [15:0] dth, logic [15:0] dph);
        pose_t p;
        if (calm == 0 && $urandom_range(99) < 12)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        kind <= k;
        d_theta <= dth;
        d_phi <= dph;
        do
            @(posedge clk);
        while (!cmd_ready);
        p = next_pose(k, longint'($signed(dth)), longint'($signed(dph)));
        pending_poses.push_back(p);
        words_sent++;
        if (k == KIND_LOOK)
            looks_sent++;
    endtask

    // Stop offering and wait until every pose word has come back.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_en <= 1'b0;
        if (idx < 3)
            home_val[idx] = longint'($signed(val));
        else if (idx < 6)
            up_val[idx - 3] = longint'($signed(val[15:0]));
        else if (idx == CFG_STEP)
            step_val = val[STEP_W-1:0];
    endtask

    function automatic logic [15:0] rand_delta();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1200) - 600);
            default: return 16'($urandom_range(0, 200) - 100);
        endcase
    endfunction

    task automatic send_random(int count);
        kind_t k;
        repeat (count)
        begin
            if ($urandom_range(9) < 4)
                k = KIND_LOOK;
            else if ($urandom_range(19) == 0)
                k = KIND_HOME;
            else
                k = kind_t'($urandom_range(KIND_DOWN));
            send_cmd(k, rand_delta(), rand_delta());
        end
    endtask

    // Every command, angle clamping at both ends and azimuth wrap both ways.
    task automatic test_directed();
        send_cmd(KIND_FWD, 16'h7fff, 16'h8000);
        send_cmd(KIND_BACK, 16'h0000, 16'hffff);
        send_cmd(KIND_RIGHT, 16'h8000, 16'h7fff);
        send_cmd(KIND_LEFT, 16'h1234, 16'h5678);
        send_cmd(KIND_UP, 16'hffff, 16'hffff);
        send_cmd(KIND_DOWN, 16'h0000, 16'h0000);
        send_cmd(KIND_LOOK, 16'h0000, 16'h0000);
        send_cmd(KIND_LOOK, 16'h7fff, 16'h7fff);
        send_cmd(KIND_LOOK, 16'h8000, 16'h8000);
        send_cmd(KIND_LOOK, 16'h0100, 16'h7fff);
        send_cmd(KIND_FWD, 16'h0000, 16'h0000);
        send_cmd(KIND_RIGHT, 16'h0000, 16'h0000);
        send_cmd(KIND_HOME, 16'h7fff, 16'h8000);
        send_cmd(KIND_LOOK, 16'h2000, 16'h2000);
        drain();
    endtask

    // Home and step at their extremes, so positions saturate both ways.
    task automatic test_saturation();
        write_reg(CFG_HOME_X, 32'h7fff_ffff);
        write_reg(CFG_HOME_Y, 32'h8000_0000);
        write_reg(CFG_HOME_Z, 32'h7fff_fff0);
        write_reg(CFG_STEP, 32'h0040_0000);
        send_cmd(KIND_HOME, 16'h0000, 16'h0000);
        send_cmd(KIND_LOOK, 16'h0000, 16'h1000);
        send_random(30);
        drain();
        write_reg(CFG_STEP, 32'hffff_ffff);
        write_reg(CFG_HOME_X, 32'h8000_0000);
        write_reg(CFG_HOME_Y, 32'h7fff_ffff);
        send_cmd(KIND_HOME, 16'h0000, 16'h0000);
        send_random(30);
        drain();
        write_reg(CFG_STEP, 32'h0000_0000);
        send_random(15);
        drain();
    endtask

    // A zero up vector keeps right; out-of-range up and a dead index follow.
    task automatic test_up_vector();
        write_reg(CFG_UP_X, 32'h0000_0000);
        write_reg(CFG_UP_Y, 32'h0000_0000);
        write_reg(CFG_UP_Z, 32'h0000_0000);
        write_reg(CFG_STEP, 32'h0004_0000);
        send_cmd(KIND_LOOK, 16'h0400, 16'h0400);
        send_cmd(KIND_RIGHT, 16'h0000, 16'h0000);
        drain();
        write_reg(CFG_UP_X, 32'hffff_8000);
        write_reg(CFG_UP_Y, 32'h0000_7fff);
        write_reg(CFG_UP_Z, 32'h0000_4000);
        write_reg(CFG_UNUSED, 32'hffff_ffff);
        send_random(30);
        drain();
    endtask

    // Long receiver hold while commands keep coming, then a full pause.
    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        send_random(12);
        drain();
        send_random(10);
        drain();
    endtask

    // Mostly random commands under random register settings.
    task automatic test_random();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_HOME_X, $urandom);
            write_reg(CFG_HOME_Y, $urandom);
            write_reg(CFG_HOME_Z, $urandom);
            write_reg(CFG_UP_X, $urandom_range(0, 32768) - 16384);
            write_reg(CFG_UP_Y, $urandom_range(0, 32768) - 16384);
            write_reg(CFG_UP_Z, $urandom_range(0, 32768) - 16384);
            write_reg(CFG_STEP, $urandom);
            calm = (phase == 2);
            send_random(60);
            drain();
        end
        calm = 0;
        write_reg(CFG_UP_X, 32'h0000_0000);
        write_reg(CFG_UP_Y, 32'h0000_4000);
        write_reg(CFG_UP_Z, 32'h0000_0000);
        write_reg(CFG_STEP, 32'h0004_199a);
        send_random(20);
        drain();
    endtask

    // Receiver: random stalls, a calm stretch, and the long hold when asked.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            pose_ready <= 1'b0;
        end
        else
            pose_ready <= (calm != 0) || ($urandom_range(99) >= 12);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on word %0d, %s: expected %h, got %h",
                         words_checked, name, want, got);
        end
    endfunction

    // Compare each pose word with the oldest expectation.
    always @(posedge clk)
    begin
        pose_t p;
        if (rst_n && pose_valid && pose_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Pose word with no command waiting for it");
            end
            else
            begin
                p = pending_poses.pop_front();
                check_field("pos_x", p.px, pos_x);
                check_field("pos_y", p.py, pos_y);
                check_field("pos_z", p.pz, pos_z);
                check_field("fwd_x", p.fx, fwd_x);
                check_field("fwd_y", p.fy, fwd_y);
                check_field("fwd_z", p.fz, fwd_z);
                check_field("right_x", p.rx, right_x);
                check_field("right_y", p.ry, right_y);
                check_field("right_z", p.rz, right_z);
                check_field("polar", p.pol, polar);
                check_field("azimuth", p.az, azimuth);
            end
            words_checked++;
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (pose_valid && pose_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        home_val = '{0, 0, 0};
        up_val = '{0, 16384, 0};
        step_val = 268698;
        go_home();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_up_vector();
        test_backpressure();
        test_random();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d commands (%0d looks), %0d pose words checked,",
                 words_sent, looks_sent, words_checked);
        $display("across saturating, degenerate-up and random register settings.");
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
